@@ hdl/plt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants and types for the piecewise-linear table converter.
// ----------------------------------------------------------------------------
package plt_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;
  localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int VAL_BITS    = 32;
  localparam int SIZE_BITS   = 5;
  localparam int DIV_BITS    = KEY_BITS + VAL_BITS + 1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // divider request from the sequencer
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [KEY_BITS-1:0] divisor;
  } plt_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } plt_div_rsp_t;
endpackage

@@ hdl/plt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plt_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plt_pkg::plt_div_req_t req,
  output plt_pkg::plt_div_rsp_t rsp
);
  import plt_pkg::*;

  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0]  quo_r, quo_nxt;
  logic [KEY_BITS:0]    rem_r, rem_nxt;
  logic [KEY_BITS-1:0]  den_r;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [KEY_BITS:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[KEY_BITS-1:0], quo_r[DIV_BITS-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = STEP_BITS'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract if it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.divisor;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !req.start |=> cnt_r == $past(cnt_r)) else $error("idle count moved");
`endif
endmodule

@@ hdl/plt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_store
// Breakpoint memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plt_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [plt_pkg::IDX_BITS-1:0]  wr_addr,
  input  logic [plt_pkg::KEY_BITS-1:0]  wr_key,
  input  logic [plt_pkg::VAL_BITS-1:0]  wr_val,
  input  logic [plt_pkg::IDX_BITS-1:0]  rd_addr,
  output logic [plt_pkg::KEY_BITS-1:0]  rd_key,
  output logic [plt_pkg::VAL_BITS-1:0]  rd_val
);
  import plt_pkg::*;

  logic [KEY_BITS-1:0] key_mem [MAX_ENTRIES];
  logic [VAL_BITS-1:0] val_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end
endmodule

@@ hdl/piecewise_linear_table_convert_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_convert_unit
// Work per word: a load word writes its entry, then rescans the n entries in use
// for the rising check; a convert word scans the same entries and, when it
// interpolates, also waits for the divider, which runs 49 steps. One word is in work
// at a time; the scan through the single read port of the breakpoint memory
// sets this. Reset clears control state and table_size; the breakpoint
// memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_convert_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [3:0]          in_entry_index,
  input  logic [15:0]         in_entry_key,
  input  logic signed [31:0]  in_entry_value,
  input  logic [15:0]         in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_converted,
  output logic                out_table_ok
);
  import plt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_DIV, S_DONE
  } state_t;

  state_t               state_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 cmd_r;
  logic [KEY_BITS-1:0]  smp_r;
  logic [CNT_BITS-1:0]  n_r;
  logic [CNT_BITS-1:0]  addr_r;   // address issued
  logic [CNT_BITS-1:0]  pos_r;    // index of data now on read port
  logic                 rvalid_r;
  logic                 found_r;
  logic signed [VAL_BITS-1:0] res_r;
  logic                 ok_r;
  logic [KEY_BITS-1:0]  pk_r;
  logic signed [VAL_BITS-1:0] pv_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic signed [VAL_BITS-1:0] out_conv_r;
  logic                 out_ok_r;

  logic [KEY_BITS-1:0]  rd_key;
  logic [VAL_BITS-1:0]  rd_val;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  rd_addr;
  plt_div_req_t         dreq;
  plt_div_rsp_t         drsp;

  logic signed [VAL_BITS:0] dv;
  logic [VAL_BITS:0]        mag;
  logic [KEY_BITS-1:0]      dk;
  logic [KEY_BITS-1:0]      kd;
  logic signed [VAL_BITS-1:0] cur_v;
  logic                     accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign wr_en    = accept && (in_cmd == CMD_LOAD);
  assign rd_addr  = addr_r[IDX_BITS-1:0];
  assign cur_v    = signed'(rd_val);

  assign dv  = {cur_v[VAL_BITS-1], cur_v} - {pv_r[VAL_BITS-1], pv_r};
  assign mag = dv[VAL_BITS] ? (VAL_BITS+1)'(0) - dv : dv;
  assign dk  = smp_r - pk_r;
  assign kd  = rd_key - pk_r;

  plt_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index),
    .wr_key  (in_entry_key),
    .wr_val  (in_entry_value),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  // one multiply here feeds the divider; product fits 16+33 bits
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = DIV_BITS'(dk) * DIV_BITS'(mag);
    dreq.divisor  = kd;
    if (state_r == S_SCAN && rvalid_r && cmd_r == CMD_CONVERT && !found_r &&
        smp_r != rd_key && smp_r < rd_key && pos_r != '0 &&
        rd_key > pk_r && smp_r >= pk_r) begin
      dreq.start = 1'b1;
    end
  end

  plt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= in_cmd;
            smp_r    <= in_sample;
            n_r      <= (size_r > SIZE_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES)
                                                          : CNT_BITS'(size_r);
            addr_r   <= '0;
            pos_r    <= '0;
            rvalid_r <= 1'b0;
            found_r  <= (in_cmd == CMD_LOAD);
            res_r    <= '0;
            ok_r     <= 1'b1;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue next address, evaluate the one returned
          if (addr_r < n_r) begin
            addr_r   <= addr_r + 1'b1;
            rvalid_r <= 1'b1;
          end else begin
            rvalid_r <= 1'b0;
          end
          pos_r <= addr_r;
          if (rvalid_r) begin
            if (pos_r != '0 && (rd_key <= pk_r || cur_v <= pv_r)) begin
              ok_r <= 1'b0;
            end
            if (!found_r) begin
              if (smp_r == rd_key) begin
                res_r <= cur_v; found_r <= 1'b1;
              end else if (smp_r < rd_key) begin
                found_r <= 1'b1;
                if (pos_r == '0 || rd_key <= pk_r || smp_r < pk_r) begin
                  res_r <= (pos_r == '0) ? cur_v : pv_r;
                end else begin
                  res_r <= pv_r;
                  neg_r <= dv[VAL_BITS];
                  state_r <= S_WAIT;
                end
              end else if (pos_r == n_r - 1'b1) begin
                res_r <= cur_v; found_r <= 1'b1;
              end
            end
            pk_r <= rd_key;
            pv_r <= cur_v;
          end
          if (!rvalid_r && addr_r >= n_r && pos_r == addr_r && state_r == S_SCAN) begin
            state_r <= S_DONE;
          end
          if (!rvalid_r && addr_r == '0 && n_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_WAIT: begin
          // keep scanning for the rising check while division runs
          if (addr_r < n_r) begin
            addr_r   <= addr_r + 1'b1;
            rvalid_r <= 1'b1;
          end else begin
            rvalid_r <= 1'b0;
          end
          pos_r <= addr_r;
          if (rvalid_r) begin
            if (pos_r != '0 && (rd_key <= pk_r || cur_v <= pv_r)) begin
              ok_r <= 1'b0;
            end
            pk_r <= rd_key;
            pv_r <= cur_v;
          end
          if (drsp.done) begin
            res_r   <= neg_r ? res_r - VAL_BITS'(drsp.quotient)
                             : res_r + VAL_BITS'(drsp.quotient);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // finish the rising scan
          if (addr_r < n_r) begin
            addr_r   <= addr_r + 1'b1;
            rvalid_r <= 1'b1;
          end else begin
            rvalid_r <= 1'b0;
          end
          pos_r <= addr_r;
          if (rvalid_r) begin
            if (pos_r != '0 && (rd_key <= pk_r || cur_v <= pv_r)) begin
              ok_r <= 1'b0;
            end
            pk_r <= rd_key;
            pv_r <= cur_v;
          end
          if (!rvalid_r && addr_r >= n_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_conv_r  <= res_r;
          out_ok_r    <= ok_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_converted = out_conv_r;
  assign out_table_ok  = out_ok_r;

`ifndef ASSERT_OFF
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accepted word while busy");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("result not presented");
  a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_WAIT) else $error("stray divider result");
`endif
endmodule
